// ===== rtl/pbtu_pkg.sv =====
// ----------------------------------------------------------------------------
// pbtu_pkg: shared definitions for the paged bus translation unit
// Operation codes, result kinds, page kinds, page constants and the result
// beat type.
// ----------------------------------------------------------------------------
package pbtu_pkg;

	localparam int PAGE_COUNT_DEF = 65536;

	localparam logic [2:0] OP_CPU_RD   = 3'd0;
	localparam logic [2:0] OP_CPU_WR   = 3'd1;
	localparam logic [2:0] OP_MAP_RD   = 3'd2;
	localparam logic [2:0] OP_MAP_WR   = 3'd3;
	localparam logic [2:0] OP_MAP_IO   = 3'd4;
	localparam logic [2:0] OP_SHADOW   = 3'd5;
	localparam logic [2:0] OP_PAGE_KND = 3'd6;

	localparam logic [2:0] RK_NONE     = 3'd0;
	localparam logic [2:0] RK_MEM_RD   = 3'd1;
	localparam logic [2:0] RK_MEM_WR   = 3'd2;
	localparam logic [2:0] RK_IO_RD    = 3'd3;
	localparam logic [2:0] RK_IO_WR    = 3'd4;
	localparam logic [2:0] RK_UNMAPPED = 3'd5;

	localparam logic [1:0] PK_NONE = 2'd0;
	localparam logic [1:0] PK_ROM  = 2'd1;
	localparam logic [1:0] PK_RAM  = 2'd2;
	localparam logic [1:0] PK_RSVD = 2'd3;

	localparam logic [16:0] IO_PAGE     = 17'h10000;
	localparam logic [15:0] VEC_MASK    = 16'hFF00;
	localparam logic [15:0] SHADOW_MASK = 16'h01FF;
	localparam logic [15:0] SHADOW_BASE = 16'hE000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] phys_page;
		logic [7:0]  offset;
		logic [7:0]  write_data;
		logic        shadow_write;
		logic [15:0] shadow_page;
	} res_t;

endpackage

// ===== rtl/pbtu_if.sv =====
// ----------------------------------------------------------------------------
// pbtu_if: request and response channels
// Valid/ready channels for bus requests and translated results.
// ----------------------------------------------------------------------------
interface pbtu_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [7:0]  bank;
	logic [15:0] address;
	logic [7:0]  data;
	logic        vector_fetch;
	logic [15:0] page_select;
	logic [16:0] target_page;
	logic [1:0]  setting;

	modport source (output valid, op, bank, address, data, vector_fetch, page_select,
		target_page, setting, input ready);
	modport sink (input valid, op, bank, address, data, vector_fetch, page_select,
		target_page, setting, output ready);
endinterface

interface pbtu_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] phys_page;
	logic [7:0]  offset;
	logic [7:0]  write_data;
	logic        shadow_write;
	logic [15:0] shadow_page;

	modport source (output valid, kind, phys_page, offset, write_data, shadow_write,
		shadow_page, input ready);
	modport sink (input valid, kind, phys_page, offset, write_data, shadow_write,
		shadow_page, output ready);
endinterface

// ===== rtl/pbtu_ram.sv =====
// ----------------------------------------------------------------------------
// pbtu_ram: generic single-port RAM
// One access per cycle; read data registered and held while not enabled.
// ----------------------------------------------------------------------------
module pbtu_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic [$clog2(D)-1:0] addr,
	input  logic                 we,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== rtl/pbtu_outreg.sv =====
// ----------------------------------------------------------------------------
// pbtu_outreg: result register
// Hold one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module pbtu_outreg
	import pbtu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        free,
	pbtu_rsp_if.source  rsp
);
	logic valid_q;
	res_t res_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.kind         = res_q.kind;
	assign rsp.phys_page    = res_q.phys_page;
	assign rsp.offset       = res_q.offset;
	assign rsp.write_data   = res_q.write_data;
	assign rsp.shadow_write = res_q.shadow_write;
	assign rsp.shadow_page  = res_q.shadow_page;
endmodule

// ===== rtl/paged_bus_translation_unit.sv =====
// ----------------------------------------------------------------------------
// paged_bus_translation_unit: CPU bus page translation
// Map lookup, page kind and shadow check, one result beat per request beat.
//
//   channel | dir | beat contents
//   req     | in  | op, bank, address, data, vector_fetch, page_select,
//           |     | target_page, setting
//   rsp     | out | kind, phys_page, offset, write_data, shadow_write,
//           |     | shadow_page
//
// A request does one map RAM read, then one page kind/shadow RAM read; the
// next request is taken in the cycle its result loads. After reset a clearing
// pass fills every page entry (identity maps, page kind none, shadow off);
// req.ready stays low meanwhile. A full result register with rsp.ready low
// holds the item in its last step and stalls req.
// ----------------------------------------------------------------------------
module paged_bus_translation_unit
	import pbtu_pkg::*;
#(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pbtu_req_if.sink  req,
	pbtu_rsp_if.source rsp
);
	localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam logic [16:0]   NP   = 17'(PAGE_COUNT);
	localparam logic [AW-1:0] LAST = AW'(PAGE_COUNT - 1);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_S1   = 2'd2;
	localparam logic [1:0] ST_S2   = 2'd3;

	logic [1:0]    st_q;
	logic [AW-1:0] clr_q;

	logic        in_fire, out_free, out_load;
	logic [15:0] in_src;
	logic        in_src_ok, in_sel_ok;

	logic [2:0]  op_q;
	logic [7:0]  off_q, data_q;
	logic        vec_q, src_ok_q, sel_ok_q;
	logic [15:0] src_q, sel_q;
	logic [1:0]  set_q;

	logic [16:0] phys_s2;
	logic        io_s2, phys_ok_s2, sp_ok_s2;

	logic [16:0] rmap_rdata, wmap_rdata, map_rd, phys1;
	logic [15:0] sp1;
	logic [1:0]  kind_rdata;
	logic        shd_rdata;

	logic [AW-1:0] map_addr, kind_addr, shd_addr;
	logic          rmap_we, wmap_we, map_re;
	logic [16:0]   rmap_wdata, wmap_wdata;
	logic          kind_we, kind_re, shd_we, shd_re, shd_wdata;
	logic [1:0]    kind_wdata;

	res_t res;

	assign in_fire   = req.valid && req.ready;
	assign req.ready = (st_q == ST_IDLE) || ((st_q == ST_S2) && out_free);
	assign out_load  = (st_q == ST_S2) && out_free;
	assign in_src    = {req.bank, req.address[15:8]};
	assign in_src_ok = {1'b0, in_src} < NP;
	assign in_sel_ok = {1'b0, req.page_select} < NP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLR;
			clr_q <= '0;
		end else begin
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						st_q <= ST_S1;
					end
				end
				ST_S1: st_q <= ST_S2;
				ST_S2: begin
					if (out_free) begin
						st_q <= in_fire ? ST_S1 : ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= req.op;
			off_q    <= req.address[7:0];
			data_q   <= req.data;
			vec_q    <= req.vector_fetch;
			src_q    <= in_src;
			src_ok_q <= in_src_ok;
			sel_q    <= req.page_select;
			sel_ok_q <= in_sel_ok;
			set_q    <= req.setting;
		end
	end

	// map RAMs: lookup or update on the accepting edge, identity fill while clearing
	always_comb begin
		map_addr   = clr_q;
		rmap_we    = 1'b0;
		wmap_we    = 1'b0;
		rmap_wdata = {{(17-AW){1'b0}}, clr_q};
		wmap_wdata = {{(17-AW){1'b0}}, clr_q};
		map_re     = 1'b0;
		if (st_q == ST_CLR) begin
			rmap_we = 1'b1;
			wmap_we = 1'b1;
		end else if (in_fire) begin
			if (req.op == OP_CPU_RD || req.op == OP_CPU_WR) begin
				map_addr = in_src[AW-1:0];
				map_re   = 1'b1;
			end else begin
				map_addr   = req.page_select[AW-1:0];
				rmap_we    = in_sel_ok && (req.op == OP_MAP_RD || req.op == OP_MAP_IO);
				wmap_we    = in_sel_ok && (req.op == OP_MAP_WR || req.op == OP_MAP_IO);
				rmap_wdata = (req.op == OP_MAP_IO) ? IO_PAGE : req.target_page;
				wmap_wdata = (req.op == OP_MAP_IO) ? IO_PAGE : req.target_page;
			end
		end
	end

	pbtu_ram #(.W(17), .D(PAGE_COUNT)) u_rmap (
		.clk(clk), .addr(map_addr), .we(rmap_we), .wdata(rmap_wdata),
		.re(map_re), .rdata(rmap_rdata)
	);

	pbtu_ram #(.W(17), .D(PAGE_COUNT)) u_wmap (
		.clk(clk), .addr(map_addr), .we(wmap_we), .wdata(wmap_wdata),
		.re(map_re), .rdata(wmap_rdata)
	);

	assign map_rd = (op_q == OP_CPU_WR) ? wmap_rdata : rmap_rdata;
	assign phys1  = (op_q == OP_CPU_RD && vec_q && map_rd != IO_PAGE) ?
		(map_rd | {1'b0, VEC_MASK}) : map_rd;
	assign sp1    = (sel_q & SHADOW_MASK) | SHADOW_BASE;

	// page kind RAM: read in the first step, written on the accepting edge
	always_comb begin
		kind_addr  = clr_q;
		kind_we    = 1'b0;
		kind_wdata = PK_NONE;
		kind_re    = 1'b0;
		if (st_q == ST_CLR) begin
			kind_we = 1'b1;
		end else if (st_q == ST_S1) begin
			kind_re   = 1'b1;
			kind_addr = (op_q == OP_SHADOW) ? sp1[AW-1:0] : phys1[AW-1:0];
		end else if (in_fire) begin
			kind_addr  = req.page_select[AW-1:0];
			kind_we    = in_sel_ok && (req.op == OP_PAGE_KND) && (req.setting != PK_RSVD);
			kind_wdata = req.setting;
		end
	end

	pbtu_ram #(.W(2), .D(PAGE_COUNT)) u_kind (
		.clk(clk), .addr(kind_addr), .we(kind_we), .wdata(kind_wdata),
		.re(kind_re), .rdata(kind_rdata)
	);

	// shadow RAM: read in the first step, written when the shadow event retires
	always_comb begin
		shd_addr  = clr_q;
		shd_we    = 1'b0;
		shd_wdata = 1'b0;
		shd_re    = 1'b0;
		if (st_q == ST_CLR) begin
			shd_we = 1'b1;
		end else if (st_q == ST_S1) begin
			shd_re   = 1'b1;
			shd_addr = phys1[AW-1:0];
		end else if (st_q == ST_S2) begin
			shd_addr  = sel_q[AW-1:0];
			shd_we    = out_free && sel_ok_q && (op_q == OP_SHADOW);
			shd_wdata = (set_q != 2'd0) && sp_ok_s2 && (kind_rdata == PK_RAM);
		end
	end

	pbtu_ram #(.W(1), .D(PAGE_COUNT)) u_shd (
		.clk(clk), .addr(shd_addr), .we(shd_we), .wdata(shd_wdata),
		.re(shd_re), .rdata(shd_rdata)
	);

	always_ff @(posedge clk) begin
		if (st_q == ST_S1) begin
			phys_s2    <= phys1;
			io_s2      <= map_rd == IO_PAGE;
			phys_ok_s2 <= phys1 < NP;
			sp_ok_s2   <= {1'b0, sp1} < NP;
		end
	end

	always_comb begin
		res = '0;
		case (op_q)
			OP_CPU_RD: begin
				res.offset = off_q;
				if (!src_ok_q) begin
					res.kind      = RK_UNMAPPED;
					res.phys_page = src_q;
				end else if (io_s2) begin
					res.kind = RK_IO_RD;
				end else if (phys_ok_s2 && (kind_rdata == PK_ROM || kind_rdata == PK_RAM)) begin
					res.kind      = RK_MEM_RD;
					res.phys_page = phys_s2[15:0];
				end else begin
					res.kind      = RK_UNMAPPED;
					res.phys_page = phys_s2[15:0];
				end
			end
			OP_CPU_WR: begin
				res.offset     = off_q;
				res.write_data = data_q;
				if (!src_ok_q) begin
					res.kind      = RK_UNMAPPED;
					res.phys_page = src_q;
				end else if (io_s2) begin
					res.kind = RK_IO_WR;
				end else if (phys_ok_s2 && kind_rdata == PK_RAM) begin
					res.kind         = RK_MEM_WR;
					res.phys_page    = phys_s2[15:0];
					res.shadow_write = shd_rdata;
					res.shadow_page  = shd_rdata ?
						((phys_s2[15:0] & SHADOW_MASK) | SHADOW_BASE) : 16'd0;
				end else begin
					res.kind      = RK_UNMAPPED;
					res.phys_page = phys_s2[15:0];
				end
			end
			default: res = '0;
		endcase
	end

	pbtu_outreg u_out (
		.clk(clk), .arst_n(arst_n), .load(out_load), .res(res),
		.free(out_free), .rsp(rsp)
	);

	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (st_q == ST_S1))
		else $error("accepted beat did not start a lookup");

	a_kind_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(kind_we && kind_re))
		else $error("page kind RAM read and written in one cycle");

	a_shadow_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.shadow_write) |-> (rsp.kind == RK_MEM_WR))
		else $error("shadow copy on a beat that is not a memory write");

	a_clear_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR && clr_q != LAST) |=> (st_q == ST_CLR && !req.ready))
		else $error("clearing pass cut short");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: paged bus translation unit testbench
// Feeds a short directed sequence of map, page kind and shadow events and CPU
// accesses, then about 500 random beats focused on a small set of hot pages so
// that maps, RAM/ROM kinds, shadow copies and vector fetches interact. A local
// page map model predicts every result beat; results are checked in order.
// ----------------------------------------------------------------------------
module tb_top
	import pbtu_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES = PAGE_COUNT_DEF;
	localparam int RANDOM_OPS = 500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [1:0] SHD_OFF = 2'd0;
	localparam logic [1:0] SHD_ON = 2'd1;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  bank;
		logic [15:0] address;
		logic [7:0]  data;
		logic        vector_fetch;
		logic [15:0] page_select;
		logic [16:0] target_page;
		logic [1:0]  setting;
		bit          drain;
	} bus_op_t;

	logic clk;
	logic arst_n;

	pbtu_req_if req();
	pbtu_rsp_if rsp();

	paged_bus_translation_unit #(.PAGE_COUNT(PAGES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic [16:0] rd_page_tab [PAGES];
	logic [16:0] wr_page_tab [PAGES];
	logic [1:0]  kind_tab [PAGES];
	bit          shadow_on [PAGES];
	logic [15:0] hot_pages [16];

	bus_op_t bus_ops [$];
	res_t    translations_due [$];
	bus_op_t cur_op;

	int gap_left;
	int stall_left;
	int accepted;
	int checked;
	int errors;
	int cycles;
	int kind_tally [6];
	int shadow_tally;
	res_t got;
	res_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [1:0] kind_of(input logic [16:0] page);
		if (page >= PAGES)
			return PK_NONE;
		return kind_tab[page[15:0]];
	endfunction

	function automatic res_t translate(input bus_op_t b);
		logic [16:0] src;
		logic [16:0] phys;
		logic [16:0] sp;
		res_t r;
		r = '0;
		src = {1'b0, b.bank, b.address[15:8]};
		if (b.op == OP_CPU_RD) begin
			r.offset = b.address[7:0];
			if (src >= PAGES) begin
				r.kind = RK_UNMAPPED;
				r.phys_page = src[15:0];
			end else begin
				phys = rd_page_tab[src[15:0]];
				if (phys == IO_PAGE) begin
					r.kind = RK_IO_RD;
				end else begin
					if (b.vector_fetch)
						phys = phys | {1'b0, VEC_MASK};
					r.phys_page = phys[15:0];
					if (kind_of(phys) == PK_ROM || kind_of(phys) == PK_RAM)
						r.kind = RK_MEM_RD;
					else
						r.kind = RK_UNMAPPED;
				end
			end
		end else if (b.op == OP_CPU_WR) begin
			r.offset = b.address[7:0];
			r.write_data = b.data;
			if (src >= PAGES) begin
				r.kind = RK_UNMAPPED;
				r.phys_page = src[15:0];
			end else begin
				phys = wr_page_tab[src[15:0]];
				if (phys == IO_PAGE) begin
					r.kind = RK_IO_WR;
				end else begin
					r.phys_page = phys[15:0];
					if (kind_of(phys) == PK_RAM) begin
						r.kind = RK_MEM_WR;
						if (shadow_on[phys[15:0]]) begin
							r.shadow_write = 1'b1;
							r.shadow_page = (phys[15:0] & SHADOW_MASK) | SHADOW_BASE;
						end
					end else begin
						r.kind = RK_UNMAPPED;
					end
				end
			end
		end else if (b.page_select < PAGES) begin
			case (b.op)
				OP_MAP_RD: rd_page_tab[b.page_select] = b.target_page;
				OP_MAP_WR: wr_page_tab[b.page_select] = b.target_page;
				OP_MAP_IO: begin
					rd_page_tab[b.page_select] = IO_PAGE;
					wr_page_tab[b.page_select] = IO_PAGE;
				end
				OP_SHADOW: begin
					sp = {1'b0, (b.page_select & SHADOW_MASK) | SHADOW_BASE};
					shadow_on[b.page_select] = (b.setting != SHD_OFF) && (kind_of(sp) == PK_RAM);
				end
				OP_PAGE_KND: begin
					if (b.setting != PK_RSVD)
						kind_tab[b.page_select] = b.setting;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic queue_op(input logic [2:0] op, input logic [7:0] bank,
		input logic [15:0] address, input logic [7:0] data, input logic vec,
		input logic [15:0] sel, input logic [16:0] tgt, input logic [1:0] setting);
		bus_op_t b;
		b.op = op;
		b.bank = bank;
		b.address = address;
		b.data = data;
		b.vector_fetch = vec;
		b.page_select = sel;
		b.target_page = tgt;
		b.setting = setting;
		b.drain = 1'b0;
		bus_ops.push_back(b);
	endtask

	function automatic logic [15:0] pick_page();
		if ($urandom_range(0, 9) < 7)
			return hot_pages[$urandom_range(0, 15)];
		return 16'($urandom);
	endfunction

	function automatic bus_op_t random_op();
		bus_op_t b;
		logic [15:0] pg;
		int r;
		int t;
		r = $urandom_range(0, 99);
		b.bank = 8'($urandom);
		b.address = 16'($urandom);
		b.data = 8'($urandom);
		b.vector_fetch = 1'($urandom);
		b.page_select = 16'($urandom);
		b.target_page = 17'($urandom_range(0, 131071));
		b.setting = 2'($urandom);
		b.drain = 1'b0;
		if (r < 28)
			b.op = OP_CPU_RD;
		else if (r < 56)
			b.op = OP_CPU_WR;
		else if (r < 64)
			b.op = OP_MAP_RD;
		else if (r < 72)
			b.op = OP_MAP_WR;
		else if (r < 76)
			b.op = OP_MAP_IO;
		else if (r < 84)
			b.op = OP_SHADOW;
		else if (r < 97)
			b.op = OP_PAGE_KND;
		else
			b.op = OP_UNUSED;
		case (b.op)
			OP_CPU_RD, OP_CPU_WR: begin
				pg = pick_page();
				b.bank = pg[15:8];
				b.address[15:8] = pg[7:0];
				b.vector_fetch = ($urandom_range(0, 3) == 0);
			end
			OP_MAP_RD, OP_MAP_WR: begin
				b.page_select = pick_page();
				t = $urandom_range(0, 9);
				if (t == 0)
					b.target_page = IO_PAGE;
				else if (t == 1)
					b.target_page = 17'($urandom_range(65537, 131071));
				else
					b.target_page = {1'b0, pick_page()};
			end
			OP_MAP_IO, OP_SHADOW: b.page_select = pick_page();
			OP_PAGE_KND: begin
				b.page_select = pick_page();
				t = $urandom_range(0, 9);
				if (t < 5)
					b.setting = PK_RAM;
				else if (t < 7)
					b.setting = PK_ROM;
				else if (t < 9)
					b.setting = PK_NONE;
				else
					b.setting = PK_RSVD;
			end
			default: ;
		endcase
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= '0;
			req.bank <= '0;
			req.address <= '0;
			req.data <= '0;
			req.vector_fetch <= 1'b0;
			req.page_select <= '0;
			req.target_page <= '0;
			req.setting <= '0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready) begin
				translations_due.push_back(translate(cur_op));
				accepted++;
				gap_left = ((accepted / 50) % 4 == 3) ? 0 : $urandom_range(0, 5);
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (bus_ops.size() > 0 &&
					!(bus_ops[0].drain && translations_due.size() != 0)) begin
					cur_op = bus_ops.pop_front();
					req.op <= cur_op.op;
					req.bank <= cur_op.bank;
					req.address <= cur_op.address;
					req.data <= cur_op.data;
					req.vector_fetch <= cur_op.vector_fetch;
					req.page_select <= cur_op.page_select;
					req.target_page <= cur_op.target_page;
					req.setting <= cur_op.setting;
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.kind = rsp.kind;
				got.phys_page = rsp.phys_page;
				got.offset = rsp.offset;
				got.write_data = rsp.write_data;
				got.shadow_write = rsp.shadow_write;
				got.shadow_page = rsp.shadow_page;
				if (translations_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result beat kind=%0d page=%h", $realtime,
							got.kind, got.phys_page);
				end else begin
					want = translations_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: beat %0d got  kind=%0d page=%h off=%h data=%h shw=%b shp=%h",
								$realtime, checked, got.kind, got.phys_page, got.offset,
								got.write_data, got.shadow_write, got.shadow_page);
							$display("%0t: beat %0d want kind=%0d page=%h off=%h data=%h shw=%b shp=%h",
								$realtime, checked, want.kind, want.phys_page, want.offset,
								want.write_data, want.shadow_write, want.shadow_page);
						end
					end
				end
				if (got.kind <= RK_UNMAPPED)
					kind_tally[got.kind]++;
				if (got.shadow_write)
					shadow_tally++;
				checked++;
				stall_left = ((checked / 50) % 4 == 1) ? 0 : $urandom_range(0, 5);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $realtime, translations_due.size());
			$display("paged_bus_translation_unit: mismatch");
			$finish;
		end
	end

	initial begin
		bus_op_t b;
		arst_n = 1'b0;
		for (int i = 0; i < PAGES; i++) begin
			rd_page_tab[i] = 17'(i);
			wr_page_tab[i] = 17'(i);
			kind_tab[i] = PK_NONE;
			shadow_on[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++) begin
			hot_pages[i] = 16'($urandom);
			hot_pages[i + 4] = (hot_pages[i] & SHADOW_MASK) | SHADOW_BASE;
			hot_pages[i + 8] = VEC_MASK | {8'h00, hot_pages[i][7:0]};
			hot_pages[i + 12] = 16'($urandom);
		end

		queue_op(OP_CPU_RD, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_PAGE_KND, 8'h00, 16'h0000, 8'h00, 1'b0, 16'hE012, 17'h0, PK_RAM);
		queue_op(OP_PAGE_KND, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0012, 17'h0, PK_RAM);
		queue_op(OP_SHADOW, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0012, 17'h0, SHD_ON);
		queue_op(OP_CPU_WR, 8'h00, 16'h12FF, 8'hFF, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_SHADOW, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0034, 17'h0, 2'd2);
		queue_op(OP_PAGE_KND, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0034, 17'h0, PK_ROM);
		queue_op(OP_CPU_WR, 8'h00, 16'h3401, 8'hA5, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_CPU_RD, 8'h00, 16'h3401, 8'h00, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_MAP_IO, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0100, 17'h0, PK_NONE);
		queue_op(OP_CPU_RD, 8'h01, 16'h00FF, 8'h00, 1'b1, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_CPU_WR, 8'h01, 16'h0080, 8'h5A, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_MAP_RD, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0200, 17'h000AB, PK_NONE);
		queue_op(OP_PAGE_KND, 8'h00, 16'h0000, 8'h00, 1'b0, 16'hFFAB, 17'h0, PK_ROM);
		queue_op(OP_CPU_RD, 8'h02, 16'h0010, 8'h00, 1'b1, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_CPU_RD, 8'h02, 16'h0010, 8'h00, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_MAP_WR, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0300, 17'h1ABCD, PK_NONE);
		queue_op(OP_CPU_WR, 8'h03, 16'h0077, 8'h3C, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_MAP_RD, 8'h00, 16'h0000, 8'h00, 1'b0, 16'hFFFF, 17'h1FFFF, PK_NONE);
		queue_op(OP_CPU_RD, 8'hFF, 16'hFFFF, 8'h00, 1'b1, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_PAGE_KND, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0012, 17'h0, PK_RSVD);
		queue_op(OP_PAGE_KND, 8'h00, 16'h0000, 8'h00, 1'b0, 16'hFFFF, 17'h0, PK_RAM);
		queue_op(OP_CPU_WR, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 16'h0000, 17'h0, PK_NONE);
		queue_op(OP_SHADOW, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0012, 17'h0, SHD_OFF);
		queue_op(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 17'h1FFFF, PK_RSVD);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			b = random_op();
			b.drain = (i % 150 == 0);
			bus_ops.push_back(b);
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (bus_ops.size() != 0 || req.valid || translations_due.size() != 0);
		repeat (8) @(posedge clk);

		$display("accepted %0d request beats, checked %0d result beats", accepted, checked);
		$display("none %0d, mem rd %0d, mem wr %0d (shadowed %0d), io rd %0d, io wr %0d, unmapped %0d",
			kind_tally[RK_NONE], kind_tally[RK_MEM_RD], kind_tally[RK_MEM_WR], shadow_tally,
			kind_tally[RK_IO_RD], kind_tally[RK_IO_WR], kind_tally[RK_UNMAPPED]);
		if (errors == 0 && translations_due.size() == 0)
			$display("paged_bus_translation_unit: match");
		else
			$display("paged_bus_translation_unit: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pbtu_pkg.sv
rtl/pbtu_if.sv
rtl/pbtu_ram.sv
rtl/pbtu_outreg.sv
rtl/paged_bus_translation_unit.sv
tb/sv/tb_top.sv
